FILE: rtl/framed_byte_ring_buffer_unit_defines.svh
// Assertion macros for the framed byte ring buffer.
// FBRB_ASSERT: checked only outside reset.
// FBRB_ASSERT_ALWAYS: checked at every clock edge, reset included.
`ifndef FRAMED_BYTE_RING_BUFFER_UNIT_DEFINES_SVH
`define FRAMED_BYTE_RING_BUFFER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define FBRB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define FBRB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FBRB_ASSERT(lbl, prop, msg)
`define FBRB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/fbrb_pkg.sv
`default_nettype none

package fbrb_pkg;

    // sizing
    localparam int DATA_DEPTH  = 256;
    localparam int FRAME_SLOTS = 16;

    localparam int LEN_W = 8;                           // length / capacity field
    localparam int BYTE_W = 8;                          // data byte
    localparam int PTR_W = $clog2(DATA_DEPTH);          // store address
    localparam int QIDX_W = $clog2(FRAME_SLOTS);        // length queue index
    localparam int CNT_W = $clog2(DATA_DEPTH + 1);      // committed byte count
    localparam int FCNT_W = $clog2(FRAME_SLOTS + 1);    // committed frame count
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // commands
    localparam logic [1:0] CMD_WR_BEGIN = 2'd0;
    localparam logic [1:0] CMD_WR_BYTE  = 2'd1;
    localparam logic [1:0] CMD_RD_BEGIN = 2'd2;
    localparam logic [1:0] CMD_RD_BYTE  = 2'd3;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_SEQ_ERR = 2'd2;

    // transfer mode
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_WRITING = 2'd1;
    localparam logic [1:0] MODE_READING = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/fbrb_cmd_if.sv
`default_nettype none

interface fbrb_cmd_if
    import fbrb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic [LEN_W-1:0]    length_value;
    logic [BYTE_W-1:0]   data_byte;

    modport source (output valid, output command, output length_value,
                    output data_byte, input ready);
    modport sink   (input valid, input command, input length_value,
                    input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/fbrb_rsp_if.sv
`default_nettype none

interface fbrb_rsp_if
    import fbrb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [LEN_W-1:0]    frame_length;
    logic [BYTE_W-1:0]   read_byte_value;
    logic                last_byte;
    logic [FCNT_W-1:0]   frames_stored;
    logic [CNT_W-1:0]    bytes_stored;

    modport source (output valid, output status, output frame_length,
                    output read_byte_value, output last_byte,
                    output frames_stored, output bytes_stored, input ready);
    modport sink   (input valid, input status, input frame_length,
                    input read_byte_value, input last_byte,
                    input frames_stored, input bytes_stored, output ready);
endinterface

`default_nettype wire

FILE: rtl/framed_byte_ring_buffer_unit.sv
// Framed byte ring buffer: a byte ring store with a queue of frame lengths.
// Channels: i_cmd carries one command per transaction (write begin, write
// byte, read begin, read byte) with a length/capacity and a data byte.
// o_rsp returns exactly one result per command: status, frame length on an
// accepted read begin, the byte on an accepted read byte, a last-byte flag,
// and the committed frame and byte counts after the command.
// Each result passes the aligning stage and then the output register.
// Throughput: one command per cycle while o_rsp.ready is high; all state is
// updated at acceptance, so back-to-back commands see each other at once.
// The read byte comes from the data store's registered read port, which is
// why the result passes one aligning stage before the output register.
// Stall: while o_rsp.ready is low the output register holds; one more
// command can be taken into the aligning stage, after that i_cmd.ready drops.
// Reset (synchronous, active low): pointers, counts and the transfer mode
// clear and both pipeline stages empty. Store and length queue contents are
// not cleared; no legal command sequence reads an entry before writing it.
`default_nettype none

`include "framed_byte_ring_buffer_unit_defines.svh"

module framed_byte_ring_buffer_unit
    import fbrb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fbrb_cmd_if.sink   i_cmd,
    fbrb_rsp_if.source o_rsp
);

    // ---------------------------------------------------------------
    // handshake / pipeline control
    // ---------------------------------------------------------------
    logic r_p_valid;    // aligning stage holds a result
    logic r_o_valid;    // output register holds a result
    logic o_adv;        // output register can load
    logic p_adv;        // aligning stage moves to output
    logic accept;

    assign o_adv  = !r_o_valid || o_rsp.ready;
    assign p_adv  = r_p_valid && o_adv;
    assign i_cmd.ready = !r_p_valid || o_adv;
    assign accept = i_cmd.valid && i_cmd.ready;

    // ---------------------------------------------------------------
    // architectural state
    // ---------------------------------------------------------------
    logic [PTR_W-1:0]  r_wr_ptr,   n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr,   n_rd_ptr;
    logic [QIDX_W-1:0] r_lq_head,  n_lq_head;
    logic [QIDX_W-1:0] r_lq_tail,  n_lq_tail;
    logic [CNT_W-1:0]  r_byte_cnt, n_byte_cnt;
    logic [FCNT_W-1:0] r_frame_cnt, n_frame_cnt;
    logic [1:0]        r_mode,     n_mode;
    logic [LEN_W-1:0]  r_remain,   n_remain;
    logic [LEN_W-1:0]  r_open_len, n_open_len;   // length of the open write frame

    // length queue: small, read only at the head, so plain flops
    logic [LEN_W-1:0]  r_lq [FRAME_SLOTS];
    logic              lq_we;

    // ---------------------------------------------------------------
    // command evaluation
    // ---------------------------------------------------------------
    logic [1:0]        c_status;
    logic [LEN_W-1:0]  c_flen;
    logic              c_last;
    logic              c_rd_byte;   // accepted read byte: result takes RAM data
    logic              ram_we;

    logic [LEN_W-1:0]  oldest_len;
    logic [CMP_W-1:0]  free_bytes;
    logic [LEN_W-1:0]  remain_dec;
    logic [CNT_W-1:0]  oldest_ext;

    assign oldest_len = r_lq[r_lq_head];
    assign free_bytes = CMP_W'(DATA_DEPTH) - CMP_W'(r_byte_cnt);
    assign remain_dec = r_remain - LEN_W'(1);
    assign oldest_ext = CNT_W'(oldest_len);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DATA_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [QIDX_W-1:0] qidx_next(input logic [QIDX_W-1:0] q);
        return (q == QIDX_W'(FRAME_SLOTS - 1)) ? '0 : q + QIDX_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_lq_head   = r_lq_head;
        n_lq_tail   = r_lq_tail;
        n_byte_cnt  = r_byte_cnt;
        n_frame_cnt = r_frame_cnt;
        n_mode      = r_mode;
        n_remain    = r_remain;
        n_open_len  = r_open_len;
        lq_we       = 1'b0;
        ram_we      = 1'b0;
        c_status    = ST_OK;
        c_flen      = '0;
        c_last      = 1'b0;
        c_rd_byte   = 1'b0;

        unique case (i_cmd.command)
            CMD_WR_BEGIN: begin
                if (i_cmd.length_value == '0
                    || CMP_W'(i_cmd.length_value) > free_bytes
                    || r_frame_cnt >= FCNT_W'(FRAME_SLOTS)
                    || r_mode != MODE_IDLE) begin
                    c_status = ST_REFUSED;
                end else begin
                    lq_we      = 1'b1;
                    n_remain   = i_cmd.length_value;
                    n_open_len = i_cmd.length_value;
                    n_mode     = MODE_WRITING;
                end
            end
            CMD_WR_BYTE: begin
                if (r_mode != MODE_WRITING) begin
                    c_status = ST_SEQ_ERR;
                end else begin
                    ram_we   = 1'b1;
                    n_wr_ptr = ptr_next(r_wr_ptr);
                    n_remain = remain_dec;
                    if (remain_dec == '0) begin
                        // commit the frame
                        c_last      = 1'b1;
                        n_byte_cnt  = r_byte_cnt + CNT_W'(r_open_len);
                        n_lq_tail   = qidx_next(r_lq_tail);
                        n_frame_cnt = r_frame_cnt + FCNT_W'(1);
                        n_mode      = MODE_IDLE;
                    end
                end
            end
            CMD_RD_BEGIN: begin
                if (r_frame_cnt == '0 || i_cmd.length_value < oldest_len
                    || r_mode != MODE_IDLE) begin
                    c_status = ST_REFUSED;
                end else begin
                    c_flen   = oldest_len;
                    n_remain = oldest_len;
                    n_mode   = MODE_READING;
                end
            end
            CMD_RD_BYTE: begin
                if (r_mode != MODE_READING) begin
                    c_status = ST_SEQ_ERR;
                end else begin
                    c_rd_byte = 1'b1;
                    n_rd_ptr  = ptr_next(r_rd_ptr);
                    n_remain  = remain_dec;
                    if (remain_dec == '0) begin
                        // release the frame
                        c_last      = 1'b1;
                        n_byte_cnt  = (r_byte_cnt >= oldest_ext) ?
                                      r_byte_cnt - oldest_ext : '0;
                        n_lq_head   = qidx_next(r_lq_head);
                        n_frame_cnt = (r_frame_cnt != '0) ?
                                      r_frame_cnt - FCNT_W'(1) : '0;
                        n_mode      = MODE_IDLE;
                    end
                end
            end
            default: begin
                c_status = ST_SEQ_ERR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_lq_head   <= '0;
            r_lq_tail   <= '0;
            r_byte_cnt  <= '0;
            r_frame_cnt <= '0;
            r_mode      <= MODE_IDLE;
            r_remain    <= '0;
            r_open_len  <= '0;
        end else if (accept) begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_lq_head   <= n_lq_head;
            r_lq_tail   <= n_lq_tail;
            r_byte_cnt  <= n_byte_cnt;
            r_frame_cnt <= n_frame_cnt;
            r_mode      <= n_mode;
            r_remain    <= n_remain;
            r_open_len  <= n_open_len;
        end
    end

    // queue entry written on write begin; contents need no reset
    always_ff @(posedge i_clk) begin
        if (accept && lq_we) begin
            r_lq[r_lq_tail] <= i_cmd.length_value;
        end
    end

    // ---------------------------------------------------------------
    // data store: write on write byte, read issued on every accept so
    // the read data lines up with the aligning stage and holds with it
    // ---------------------------------------------------------------
    logic [BYTE_W-1:0] ram_rdata;

    fbrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DATA_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_cmd.data_byte),
        .i_re    (accept),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // aligning stage
    // ---------------------------------------------------------------
    logic [1:0]        r_p_status;
    logic [LEN_W-1:0]  r_p_flen;
    logic              r_p_last;
    logic              r_p_rd_byte;
    logic [FCNT_W-1:0] r_p_frames;
    logic [CNT_W-1:0]  r_p_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= 1'b1;
        end else if (p_adv) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_status  <= c_status;
            r_p_flen    <= c_flen;
            r_p_last    <= c_last;
            r_p_rd_byte <= c_rd_byte;
            r_p_frames  <= n_frame_cnt;
            r_p_bytes   <= n_byte_cnt;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic [1:0]        r_o_status;
    logic [LEN_W-1:0]  r_o_flen;
    logic [BYTE_W-1:0] r_o_rbyte;
    logic              r_o_last;
    logic [FCNT_W-1:0] r_o_frames;
    logic [CNT_W-1:0]  r_o_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_adv) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_o_status <= r_p_status;
            r_o_flen   <= r_p_flen;
            r_o_rbyte  <= r_p_rd_byte ? ram_rdata : '0;
            r_o_last   <= r_p_last;
            r_o_frames <= r_p_frames;
            r_o_bytes  <= r_p_bytes;
        end
    end

    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.frame_length    = r_o_flen;
    assign o_rsp.read_byte_value = r_o_rbyte;
    assign o_rsp.last_byte       = r_o_last;
    assign o_rsp.frames_stored   = r_o_frames;
    assign o_rsp.bytes_stored    = r_o_bytes;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `FBRB_ASSERT(a_frame_cnt_max, r_frame_cnt <= FCNT_W'(FRAME_SLOTS), "frame count overflow")
    `FBRB_ASSERT(a_byte_cnt_max, r_byte_cnt <= CNT_W'(DATA_DEPTH), "byte count overflow")
    `FBRB_ASSERT(a_empty_no_bytes, r_frame_cnt == '0 |-> r_byte_cnt == '0, "bytes without frames")
    `FBRB_ASSERT(a_stage_holds, r_p_valid && !o_adv |=> r_p_valid, "aligning stage dropped a result")
    `FBRB_ASSERT(a_last_to_idle, accept && c_last |=> r_mode == MODE_IDLE, "mode not idle after last byte")

endmodule

`default_nettype wire

FILE: rtl/fbrb_ram.sv
`default_nettype none

// simple dual port RAM, registered read, read data holds when i_re is low
module fbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
